>>> hdl/swm_pkg.sv
// swm_pkg: shared widths and register map of the sliding window median core
// no dependencies; compiled first
`timescale 1ns / 1ps

package swm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int MEDIAN_W   = 16;
   localparam int SUM_W      = 48;
   localparam int WLEN_W     = 13;
   localparam int WLEN_MAX   = 2 ** WLEN_W - 1;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_LENGTH = CSR_ADDR_W'(0);

endpackage

>>> hdl/swm_if.sv
// swm_req_if / swm_rsp_if: valid-ready channels of the sliding window median core
// depends on swm_pkg for payload widths
`timescale 1ns / 1ps

interface swm_req_if;
   logic                         valid;
   logic                         ready;
   logic [swm_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface swm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [swm_pkg::MEDIAN_W-1:0] median;
   logic [swm_pkg::SUM_W-1:0]    median_sum;

   modport source (output valid, output median, output median_sum, input ready);
   modport sink   (input valid, input median, input median_sum, output ready);
endinterface

>>> hdl/swm_ram.sv
// swm_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module swm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/sliding_window_median_core.sv
// Sliding window median over unsigned samples using a count tree held in one ram, with a
// second ram as the sample delay line. Once the window is full each sample costs an insert,
// a removal and a rank descent (while filling, an insert and a descent when a result is due,
// else only the insert): the count ram walks one tree level per cycle for each of them.
// After reset and after every write of window_length all 2**(VALUE_BITS+1) entries of the
// count ram are cleared one entry per cycle, and while that runs no sample transaction is
// taken. Depends on swm_pkg, swm_if and swm_ram.
`timescale 1ns / 1ps

module sliding_window_median_core #(
   parameter int VALUE_BITS   = 16,
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   swm_req_if.sink                        req_if,
   swm_rsp_if.source                      rsp_if,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [swm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [swm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [swm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   import swm_pkg::*;

   localparam int VB      = VALUE_BITS;
   localparam int NODE_W  = VB + 1;
   localparam int EFF_MAX = (WINDOW_DEPTH < WLEN_MAX) ? WINDOW_DEPTH : WLEN_MAX;
   localparam int CNT_W   = $clog2(EFF_MAX + 2);
   localparam int POS_W   = $clog2(WINDOW_DEPTH);
   localparam int DIFF_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DESC,
      ST_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    clr_ff, clr_in;
   logic [WLEN_W-1:0]    wl_ff, wl_in;
   logic [CNT_W-1:0]     seen_ff, seen_in;
   logic [POS_W-1:0]     wp_ff, wp_in;
   logic [SUM_W-1:0]     total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MEDIAN_W-1:0]  rsp_med_ff, rsp_med_in;
   logic [VB-1:0]        sample_ff, sample_in;
   logic [POS_W-1:0]     slot_ff, slot_in;
   logic [VB-1:0]        old_ff, old_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [NODE_W-1:0]    prev_ff, prev_in;
   logic [CNT_W-1:0]     rank_ff, rank_in;
   logic [VB-1:0]        med_ff, med_in;
   logic                 full_ff, full_in;
   logic                 emit_ff, emit_in;
   logic                 up_ff, up_in;
   logic                 wr_ff, wr_in;
   logic                 grab_ff, grab_in;
   logic                 pend_ff, pend_in;

   logic                 cnt_we;
   logic [NODE_W-1:0]    cnt_waddr;
   logic [CNT_W-1:0]     cnt_wdata;
   logic [NODE_W-1:0]    cnt_raddr;
   logic [CNT_W-1:0]     cnt_rdata;
   logic                 dly_we;
   logic [VB-1:0]        dly_rdata;

   logic [CNT_W-1:0]     len_eff;
   logic [CNT_W-1:0]     rank_init;
   logic [DIFF_W-1:0]    wp_ext, len_ext;
   logic [POS_W-1:0]     old_slot;
   logic [VB-1:0]        sample_sat;
   logic                 req_fire;
   logic                 csr_we;
   logic [NODE_W-1:0]    left_node, next_node;

   // effective window length and lower-median rank
   always_comb begin
      if (wl_ff == '0) begin
         len_eff = CNT_W'(1);
      end else if (32'(wl_ff) > 32'(EFF_MAX)) begin
         len_eff = CNT_W'(EFF_MAX);
      end else begin
         len_eff = CNT_W'(wl_ff);
      end
      rank_init = CNT_W'(({1'b0, len_eff} + (CNT_W + 1)'(1)) >> 1);
   end

   // delay line slot of the sample leaving the window
   always_comb begin
      wp_ext  = DIFF_W'(wp_ff);
      len_ext = DIFF_W'(len_eff);
      if (wp_ext >= len_ext) begin
         old_slot = POS_W'(wp_ext - len_ext);
      end else begin
         old_slot = POS_W'(wp_ext + DIFF_W'(WINDOW_DEPTH) - len_ext);
      end
   end

   always_comb begin
      if (VB < SAMPLE_W && (req_if.sample >> VB) != '0) begin
         sample_sat = '1;
      end else begin
         sample_sat = VB'(req_if.sample);
      end
   end

   assign req_fire  = req_if.valid && (state_ff == ST_IDLE);
   assign csr_we    = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr == REG_WINDOW_LENGTH);
   assign left_node = {node_ff[VB-1:0], 1'b0};

   always_comb begin
      if (rank_ff <= cnt_rdata) begin
         next_node = left_node;
      end else begin
         next_node = left_node | NODE_W'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wl_in        = wl_ff;
      seen_in      = seen_ff;
      wp_in        = wp_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_med_in   = rsp_med_ff;
      sample_in    = sample_ff;
      slot_in      = slot_ff;
      old_in       = old_ff;
      node_in      = node_ff;
      prev_in      = prev_ff;
      rank_in      = rank_ff;
      med_in       = med_ff;
      full_in      = full_ff;
      emit_in      = emit_ff;
      up_in        = up_ff;
      wr_in        = wr_ff;
      grab_in      = grab_ff;
      pend_in      = pend_ff;

      cnt_we    = 1'b0;
      cnt_waddr = prev_ff;
      cnt_wdata = '0;
      cnt_raddr = node_ff;
      dly_we    = 1'b0;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            clr_in    = clr_ff + NODE_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               sample_in = sample_sat;
               slot_in   = wp_ff;
               wp_in     = (32'(wp_ff) == WINDOW_DEPTH - 1) ? '0 : wp_ff + POS_W'(1);
               full_in   = seen_ff >= len_eff;
               emit_in   = (seen_ff >= len_eff)
                           || (({1'b0, seen_ff} + (CNT_W + 1)'(1)) >= {1'b0, len_eff});
               if (seen_ff < len_eff) begin
                  seen_in = seen_ff + CNT_W'(1);
               end
               node_in  = {1'b1, sample_sat};
               up_in    = 1'b1;
               wr_in    = 1'b0;
               grab_in  = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (grab_ff) begin
               old_in  = dly_rdata;
               grab_in = 1'b0;
            end
            if (wr_ff) begin
               cnt_we = 1'b1;
               if (up_ff) begin
                  cnt_wdata = cnt_rdata + CNT_W'(1);
               end else if (cnt_rdata != '0) begin
                  cnt_wdata = cnt_rdata - CNT_W'(1);
               end
            end
            prev_in = node_ff;
            node_in = node_ff >> 1;
            wr_in   = 1'b1;
            if (node_ff == NODE_W'(1)) begin
               wr_in   = 1'b0;
               pend_in = 1'b0;
               rank_in = rank_init;
               if (up_ff) begin
                  dly_we = 1'b1;
                  if (full_ff) begin
                     node_in = {1'b1, old_ff};
                     up_in   = 1'b0;
                  end else if (emit_ff) begin
                     node_in  = NODE_W'(1);
                     state_in = ST_DESC;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  node_in  = NODE_W'(1);
                  state_in = ST_DESC;
               end
            end
         end
         ST_DESC: begin
            if (!pend_ff) begin
               cnt_raddr = left_node;
               pend_in   = 1'b1;
            end else begin
               node_in   = next_node;
               cnt_raddr = {next_node[VB-1:0], 1'b0};
               if (rank_ff > cnt_rdata) begin
                  rank_in = rank_ff - cnt_rdata;
               end
               if (next_node[VB]) begin
                  med_in   = next_node[VB-1:0];
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_med_in   = MEDIAN_W'(med_ff);
               total_in     = total_ff + SUM_W'(med_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase

      // new stream
      if (csr_we) begin
         wl_in    = csr_pwdata[WLEN_W-1:0];
         seen_in  = '0;
         wp_in    = '0;
         total_in = '0;
         clr_in   = '0;
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wl_ff        <= WLEN_W'(1);
         seen_ff      <= '0;
         wp_ff        <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         up_ff        <= 1'b0;
         wr_ff        <= 1'b0;
         grab_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         full_ff      <= 1'b0;
         emit_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wl_ff        <= wl_in;
         seen_ff      <= seen_in;
         wp_ff        <= wp_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         up_ff        <= up_in;
         wr_ff        <= wr_in;
         grab_ff      <= grab_in;
         pend_ff      <= pend_in;
         full_ff      <= full_in;
         emit_ff      <= emit_in;
      end
      rsp_med_ff <= rsp_med_in;
      sample_ff  <= sample_in;
      slot_ff    <= slot_in;
      old_ff     <= old_in;
      node_ff    <= node_in;
      prev_ff    <= prev_in;
      rank_ff    <= rank_in;
      med_ff     <= med_in;
   end

   // count tree: node 1 is the root, leaves at 2**VALUE_BITS + value
   swm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (2 ** NODE_W)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   swm_ram #(
      .WIDTH (VB),
      .DEPTH (WINDOW_DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (dly_we),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_addr (old_slot),
      .rd_data (dly_rdata)
   );

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.median     = rsp_med_ff;
   assign rsp_if.median_sum = total_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_WINDOW_LENGTH) ? CSR_DATA_W'(wl_ff) : '0;

endmodule
